/* hdl/segmented_handle_table_defines.svh */
// Assertion macros used by the handle table controller.
`ifndef SEGMENTED_HANDLE_TABLE_DEFINES_SVH
`define SEGMENTED_HANDLE_TABLE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define SHT_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define SHT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hdl/sht_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sht_pkg;

    localparam int OBJ_W      = 32;
    localparam int REFIDX_W   = 12;
    localparam int REFSER_W   = 14;
    localparam int KIND_W     = 2;
    localparam int COOKIE_W   = 13;
    localparam int HOLE_W     = 13;
    localparam int MAXE_W     = 13;
    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_KIND  = 1'b1;

    localparam logic [MAXE_W-1:0] MAX_ENTRIES_RST = 13'd4096;
    localparam logic [KIND_W-1:0] TABLE_KIND_RST  = 2'd1;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_POP    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_OVERFLOW    = 3'd1,
        ST_INVALID_REF = 3'd2,
        ST_BELOW_SEG   = 3'd3,
        ST_ABOVE_TOP   = 3'd4,
        ST_HOLE        = 3'd5,
        ST_MISMATCH    = 3'd6,
        ST_BAD_COOKIE  = 3'd7
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_SCAN,
        S_ADD_CHK,
        S_ADD_WR,
        S_RM_CHK,
        S_ABS,
        S_ABS_CHK,
        S_LK_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op                  op;
        logic [OBJ_W-1:0]     obj_handle;
        logic [REFIDX_W-1:0]  ref_index;
        logic [REFSER_W-1:0]  ref_serial;
        logic [KIND_W-1:0]    ref_kind;
        logic [COOKIE_W-1:0]  cookie_top;
        logic [COOKIE_W-1:0]  cookie_holes;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [REFIDX_W-1:0]  out_index;
        logic [REFSER_W-1:0]  out_serial;
        logic [KIND_W-1:0]    out_kind;
        logic [OBJ_W-1:0]     out_object;
    } t_result;

endpackage

`default_nettype wire

/* hdl/sht_slot_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module sht_slot_mem #(
    parameter int DEPTH  = 4096,
    parameter int AW     = 12,
    parameter int META_W = 15
) (
    input  wire logic                        i_clk,
    input  wire logic [AW-1:0]               i_rd_addr,
    output logic      [META_W-1:0]           o_meta_rdata,
    output logic      [sht_pkg::OBJ_W-1:0]   o_obj_rdata,
    input  wire logic                        i_meta_we,
    input  wire logic                        i_obj_we,
    input  wire logic [AW-1:0]               i_wr_addr,
    input  wire logic [META_W-1:0]           i_meta_wdata,
    input  wire logic [sht_pkg::OBJ_W-1:0]   i_obj_wdata
);

    logic [META_W-1:0]         r_meta [DEPTH];
    logic [sht_pkg::OBJ_W-1:0] r_obj  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_meta_we) begin
            r_meta[i_wr_addr] <= i_meta_wdata;
        end
        o_meta_rdata <= r_meta[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_obj_we) begin
            r_obj[i_wr_addr] <= i_obj_wdata;
        end
        o_obj_rdata <= r_obj[i_rd_addr];
    end

endmodule

`default_nettype wire

/* hdl/sht_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "segmented_handle_table_defines.svh"

module sht_ctrl #(
    parameter int CAPACITY    = 4096,
    parameter int SERIAL_BITS = 14,
    parameter int IDX_W       = 12,
    parameter int CNT_W       = 13
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire sht_pkg::t_req                 i_req,
    output logic                               o_ready,
    input  wire logic                          i_out_free,
    output logic                               o_done,
    output sht_pkg::t_result                   o_res,
    input  wire logic [sht_pkg::MAXE_W-1:0]    i_max_entries,
    input  wire logic [sht_pkg::KIND_W-1:0]    i_table_kind,
    output logic      [IDX_W-1:0]              o_rd_addr,
    input  wire logic [SERIAL_BITS:0]          i_meta_rdata,
    input  wire logic [sht_pkg::OBJ_W-1:0]     i_obj_rdata,
    output logic                               o_meta_we,
    output logic                               o_obj_we,
    output logic      [IDX_W-1:0]              o_wr_addr,
    output logic      [SERIAL_BITS:0]          o_meta_wdata,
    output logic      [sht_pkg::OBJ_W-1:0]     o_obj_wdata
);

    localparam int W     = (CNT_W > sht_pkg::COOKIE_W) ? CNT_W : sht_pkg::COOKIE_W;
    localparam int CMP_W = (SERIAL_BITS > sht_pkg::REFSER_W) ? SERIAL_BITS
                                                             : sht_pkg::REFSER_W;
    localparam int RI_W  = sht_pkg::REFIDX_W;
    localparam int RS_W  = sht_pkg::REFSER_W;
    localparam int HW    = sht_pkg::HOLE_W;

    sht_pkg::t_state  r_state, n_state;
    sht_pkg::t_req    r_req, n_req;
    sht_pkg::t_result r_res, n_res;
    logic [CNT_W-1:0] r_top, n_top;
    logic [CNT_W-1:0] r_hwm, n_hwm;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic [HW-1:0]    r_hole, n_hole;
    logic [HW-1:0]    r_holes, n_holes;
    logic [IDX_W-1:0] r_slot, n_slot;
    logic             r_filled, n_filled;
    logic             r_rd_valid, n_rd_valid;

    logic [W-1:0]           top_w, idx_w, ctop_w, ptr_w, limit_w;
    logic [HW-1:0]          seg_holes;
    logic [IDX_W-1:0]       top_addr, idx_addr, ptr_dec_addr;
    logic                   rd_live;
    logic [SERIAL_BITS-1:0] rd_ser, ser_inc;
    logic                   ref_match;

    assign top_w   = W'(r_top);
    assign idx_w   = W'(r_req.ref_index);
    assign ctop_w  = W'(r_req.cookie_top);
    assign ptr_w   = W'(r_ptr);
    assign limit_w = (W'(i_max_entries) < W'(CAPACITY)) ? W'(i_max_entries) : W'(CAPACITY);

    assign seg_holes = (r_hole > r_req.cookie_holes) ? r_hole - r_req.cookie_holes : '0;

    assign top_addr     = IDX_W'(r_top);
    assign idx_addr     = IDX_W'(r_req.ref_index);
    assign ptr_dec_addr = IDX_W'(r_ptr - CNT_W'(1));

    // Entries at or above the high-water mark were never written and read as cleared.
    assign rd_live   = i_meta_rdata[SERIAL_BITS] & r_rd_valid;
    assign rd_ser    = r_rd_valid ? i_meta_rdata[SERIAL_BITS-1:0] : '0;
    assign ser_inc   = rd_ser + SERIAL_BITS'(1);
    assign ref_match = (CMP_W'(rd_ser) == CMP_W'(r_req.ref_serial))
                       && (r_req.ref_kind == i_table_kind);

    assign n_rd_valid = CNT_W'(o_rd_addr) < r_hwm;

    assign o_ready     = (r_state == sht_pkg::S_IDLE);
    assign o_res       = r_res;
    assign o_obj_wdata = r_req.obj_handle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sht_pkg::S_IDLE;
            r_top   <= '0;
            r_hwm   <= '0;
            r_hole  <= '0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_hwm   <= n_hwm;
            r_hole  <= n_hole;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_res      <= n_res;
        r_ptr      <= n_ptr;
        r_holes    <= n_holes;
        r_slot     <= n_slot;
        r_filled   <= n_filled;
        r_rd_valid <= n_rd_valid;
    end

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_res        = r_res;
        n_top        = r_top;
        n_hwm        = r_hwm;
        n_hole       = r_hole;
        n_ptr        = r_ptr;
        n_holes      = r_holes;
        n_slot       = r_slot;
        n_filled     = r_filled;
        o_rd_addr    = r_slot;
        o_wr_addr    = r_slot;
        o_meta_we    = 1'b0;
        o_obj_we     = 1'b0;
        o_meta_wdata = {1'b0, rd_ser};
        o_done       = 1'b0;

        case (r_state)
            sht_pkg::S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_state = sht_pkg::S_DECODE;
                end
            end

            sht_pkg::S_DECODE: begin
                n_res   = '0;
                n_state = sht_pkg::S_DONE;
                case (r_req.op)
                    sht_pkg::OP_ADD: begin
                        if (r_req.obj_handle == '0) begin
                            n_res.status = sht_pkg::ST_INVALID_REF;
                        end else if (top_w >= limit_w) begin
                            n_res.status = sht_pkg::ST_OVERFLOW;
                        end else if (seg_holes != '0) begin
                            n_ptr   = r_top;
                            n_state = sht_pkg::S_ADD_SCAN;
                        end else begin
                            o_rd_addr = top_addr;
                            n_slot    = top_addr;
                            n_filled  = 1'b0;
                            n_state   = sht_pkg::S_ADD_WR;
                        end
                    end
                    sht_pkg::OP_REMOVE: begin
                        if (idx_w < ctop_w) begin
                            n_res.status = sht_pkg::ST_BELOW_SEG;
                        end else if (idx_w >= top_w) begin
                            n_res.status = sht_pkg::ST_ABOVE_TOP;
                        end else begin
                            o_rd_addr = idx_addr;
                            n_state   = sht_pkg::S_RM_CHK;
                        end
                    end
                    sht_pkg::OP_LOOKUP: begin
                        if (r_req.ref_kind == '0) begin
                            n_res.status = sht_pkg::ST_INVALID_REF;
                        end else if (idx_w >= top_w) begin
                            n_res.status = sht_pkg::ST_ABOVE_TOP;
                        end else begin
                            o_rd_addr = idx_addr;
                            n_state   = sht_pkg::S_LK_CHK;
                        end
                    end
                    sht_pkg::OP_POP: begin
                        if (ctop_w > top_w || r_req.cookie_holes >= r_req.cookie_top) begin
                            n_res.status = sht_pkg::ST_BAD_COOKIE;
                        end
                    end
                    default: begin
                        n_res.status = sht_pkg::ST_OK;
                    end
                endcase
            end

            sht_pkg::S_ADD_SCAN: begin
                if (ptr_w > ctop_w) begin
                    o_rd_addr = ptr_dec_addr;
                    n_ptr     = r_ptr - CNT_W'(1);
                    n_state   = sht_pkg::S_ADD_CHK;
                end else begin
                    o_rd_addr = top_addr;
                    n_slot    = top_addr;
                    n_filled  = 1'b0;
                    n_state   = sht_pkg::S_ADD_WR;
                end
            end

            sht_pkg::S_ADD_CHK: begin
                o_rd_addr = IDX_W'(r_ptr);
                if (!rd_live) begin
                    n_slot   = IDX_W'(r_ptr);
                    n_filled = 1'b1;
                    n_state  = sht_pkg::S_ADD_WR;
                end else begin
                    n_state = sht_pkg::S_ADD_SCAN;
                end
            end

            sht_pkg::S_ADD_WR: begin
                o_meta_we    = 1'b1;
                o_obj_we     = 1'b1;
                o_meta_wdata = {1'b1, ser_inc};
                if (r_filled) begin
                    n_hole = r_hole - HW'(1);
                end else begin
                    n_top = r_top + CNT_W'(1);
                    if (n_top > r_hwm) begin
                        n_hwm = n_top;
                    end
                end
                n_res.out_index  = RI_W'(r_slot);
                n_res.out_serial = RS_W'(CMP_W'(ser_inc));
                n_res.out_kind   = i_table_kind;
                n_state          = sht_pkg::S_DONE;
            end

            sht_pkg::S_RM_CHK: begin
                o_wr_addr    = idx_addr;
                o_meta_wdata = {1'b0, rd_ser};
                n_state      = sht_pkg::S_DONE;
                if (idx_w + W'(1) == top_w) begin
                    if (!ref_match) begin
                        n_res.status = sht_pkg::ST_MISMATCH;
                    end else begin
                        o_meta_we = 1'b1;
                        if (seg_holes != '0) begin
                            n_ptr   = r_top - CNT_W'(1);
                            n_holes = seg_holes;
                            n_state = sht_pkg::S_ABS;
                        end else begin
                            n_top = r_top - CNT_W'(1);
                        end
                    end
                end else if (!rd_live) begin
                    n_res.status = sht_pkg::ST_HOLE;
                end else if (!ref_match) begin
                    n_res.status = sht_pkg::ST_MISMATCH;
                end else begin
                    o_meta_we = 1'b1;
                    n_hole    = r_hole + HW'(1);
                end
            end

            sht_pkg::S_ABS: begin
                if (ptr_w > ctop_w && r_holes != '0) begin
                    o_rd_addr = ptr_dec_addr;
                    n_state   = sht_pkg::S_ABS_CHK;
                end else begin
                    n_top   = r_ptr;
                    n_hole  = r_holes + r_req.cookie_holes;
                    n_state = sht_pkg::S_DONE;
                end
            end

            sht_pkg::S_ABS_CHK: begin
                if (rd_live) begin
                    n_top   = r_ptr;
                    n_hole  = r_holes + r_req.cookie_holes;
                    n_state = sht_pkg::S_DONE;
                end else begin
                    n_holes = r_holes - HW'(1);
                    n_ptr   = r_ptr - CNT_W'(1);
                    n_state = sht_pkg::S_ABS;
                end
            end

            sht_pkg::S_LK_CHK: begin
                n_state = sht_pkg::S_DONE;
                if (!rd_live) begin
                    n_res.status = sht_pkg::ST_HOLE;
                end else if (!ref_match) begin
                    n_res.status = sht_pkg::ST_MISMATCH;
                end else begin
                    n_res.out_object = i_obj_rdata;
                end
            end

            sht_pkg::S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = sht_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = sht_pkg::S_IDLE;
            end
        endcase
    end

    `SHT_ASSERT_ALWAYS(a_top_below_hwm, i_clk, i_rst_n, r_top <= r_hwm, "top above high-water mark")
    `SHT_ASSERT_ALWAYS(a_hwm_in_range, i_clk, i_rst_n, r_hwm <= CNT_W'(CAPACITY), "high-water mark beyond capacity")
    `SHT_ASSERT_IMPLY(a_absorb_holes, i_clk, i_rst_n, r_state == sht_pkg::S_ABS_CHK, r_holes != '0, "absorb step without holes")
    `SHT_ASSERT_IMPLY(a_scan_in_seg, i_clk, i_rst_n, r_state == sht_pkg::S_ADD_CHK, ptr_w >= ctop_w, "hole scan below segment")

endmodule

`default_nettype wire

/* hdl/segmented_handle_table.sv */
`timescale 1ns / 1ps
`default_nettype none

// Segmented handle table: each request transfer on the slave side yields exactly one result
// transfer on the master side, in order. A plain add, lookup or remove reads the slot memory
// once before its result goes to the output register; a pop check or a request refused at
// decode reads nothing. An add that searches for a hole reads the slots from the top down
// towards the segment bottom, one slot per read, until it finds a free one. A remove of the
// top entry that absorbs holes reads the slots below it one by one while they are free, at
// most as many as the segment holds holes. The slot memory has a registered read: the
// control sequencer issues one read and tests its data in the next cycle. Only one request
// is in the block at a time; a finished result waits in the output register while the next
// request is accepted, and a request that finishes while that register is still held waits
// in the sequencer. The slot memory needs no clearing pass after reset: a high-water mark
// makes slots that were never used read as empty.
module segmented_handle_table #(
    parameter int CAPACITY    = 4096,
    parameter int SERIAL_BITS = 14
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // obj_handle, ref_index, ref_serial, ref_kind, cookie_top, cookie_holes (from bit 0 up)
    input  wire logic [sht_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // opcode
    input  wire logic [sht_pkg::IN_USER_W-1:0]      s_axis_tuser,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // status, out_index, out_serial, out_kind, out_object (from bit 0 up)
    output logic      [sht_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic                               i_cfg_we,
    input  wire logic [sht_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [sht_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [sht_pkg::MAXE_W-1:0] r_max_entries;
    logic [sht_pkg::KIND_W-1:0] r_table_kind;
    logic                       r_m_valid;
    logic [sht_pkg::OUT_DATA_W-1:0] r_m_data;

    sht_pkg::t_req    req;
    sht_pkg::t_result res;
    logic             start, done, out_free;

    logic [IDX_W-1:0]          rd_addr, wr_addr;
    logic [SERIAL_BITS:0]      meta_rdata, meta_wdata;
    logic [sht_pkg::OBJ_W-1:0] obj_rdata, obj_wdata;
    logic                      meta_we, obj_we;

    assign req.op           = sht_pkg::t_op'(s_axis_tuser);
    assign req.obj_handle   = s_axis_tdata[31:0];
    assign req.ref_index    = s_axis_tdata[43:32];
    assign req.ref_serial   = s_axis_tdata[57:44];
    assign req.ref_kind     = s_axis_tdata[59:58];
    assign req.cookie_top   = s_axis_tdata[72:60];
    assign req.cookie_holes = s_axis_tdata[85:73];

    assign start    = s_axis_tvalid & s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= sht_pkg::MAX_ENTRIES_RST;
            r_table_kind  <= sht_pkg::TABLE_KIND_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sht_pkg::CFG_MAX_ENTRIES: r_max_entries <= i_cfg_wdata;
                sht_pkg::CFG_TABLE_KIND:  r_table_kind  <= i_cfg_wdata[sht_pkg::KIND_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (done) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_m_data <= {1'b0, res.out_object, res.out_kind, res.out_serial,
                         res.out_index, res.status};
        end
    end

    sht_ctrl #(
        .CAPACITY    (CAPACITY),
        .SERIAL_BITS (SERIAL_BITS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_req         (req),
        .o_ready       (s_axis_tready),
        .i_out_free    (out_free),
        .o_done        (done),
        .o_res         (res),
        .i_max_entries (r_max_entries),
        .i_table_kind  (r_table_kind),
        .o_rd_addr     (rd_addr),
        .i_meta_rdata  (meta_rdata),
        .i_obj_rdata   (obj_rdata),
        .o_meta_we     (meta_we),
        .o_obj_we      (obj_we),
        .o_wr_addr     (wr_addr),
        .o_meta_wdata  (meta_wdata),
        .o_obj_wdata   (obj_wdata)
    );

    sht_slot_mem #(
        .DEPTH  (CAPACITY),
        .AW     (IDX_W),
        .META_W (SERIAL_BITS + 1)
    ) u_mem (
        .i_clk        (i_clk),
        .i_rd_addr    (rd_addr),
        .o_meta_rdata (meta_rdata),
        .o_obj_rdata  (obj_rdata),
        .i_meta_we    (meta_we),
        .i_obj_we     (obj_we),
        .i_wr_addr    (wr_addr),
        .i_meta_wdata (meta_wdata),
        .i_obj_wdata  (obj_wdata)
    );

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int CAPACITY    = 4096;
    localparam int TOP_CAP     = 96;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASES      = 6;

    typedef struct {
        sht_pkg::t_op op;
        logic [31:0]  obj;
        logic [11:0]  idx;
        logic [13:0]  ser;
        logic [1:0]   kind;
        logic [12:0]  ctop;
        logic [12:0]  choles;
    } t_handle_req;

    typedef struct {
        sht_pkg::t_status status;
        logic [11:0]      index;
        logic [13:0]      serial;
        logic [1:0]       kind;
        logic [31:0]      object;
    } t_handle_resp;

    typedef struct {
        t_handle_req  req;
        bit           typed;
        t_handle_resp want;
    } t_plan_row;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic [sht_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [sht_pkg::IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [sht_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic [sht_pkg::CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [sht_pkg::CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    // Local copy of the table.
    logic [31:0] slot_obj  [CAPACITY] = '{default: '0};
    logic [13:0] slot_ser  [CAPACITY] = '{default: '0};
    bit          slot_live [CAPACITY] = '{default: 1'b0};
    int unsigned top_m   = 0;
    int unsigned holes_m = 0;
    int unsigned max_m   = 4096;
    logic [1:0]  kind_m  = 2'd1;

    t_handle_resp results_due [$];
    int unsigned  errors   = 0;
    int unsigned  checked  = 0;
    int unsigned  cycles   = 0;
    int unsigned  snd_idle = 35;
    int unsigned  rcv_idle = 57;
    int unsigned  op_count [4] = '{default: 0};

    int unsigned phase_max   [PHASES] = '{16, 4096, 1, 0, 8191, 40};
    int unsigned phase_kind  [PHASES] = '{1, 2, 3, 0, 2, 1};
    int unsigned phase_items [PHASES] = '{300, 300, 150, 100, 250, 250};
    int unsigned phase_snd   [PHASES] = '{35, 35, 57, 57, 0, 0};
    int unsigned phase_rcv   [PHASES] = '{57, 57, 35, 35, 0, 0};

    t_plan_row plan [26] = '{
        '{'{sht_pkg::OP_POP, 0, 0, 0, 0, 0, 0}, 1, '{sht_pkg::ST_BAD_COOKIE, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_LOOKUP, 0, 0, 0, 0, 0, 0}, 1, '{sht_pkg::ST_INVALID_REF, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_LOOKUP, 0, 4095, 16383, 3, 0, 0}, 1,
          '{sht_pkg::ST_ABOVE_TOP, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_ADD, 0, 0, 0, 1, 0, 0}, 1, '{sht_pkg::ST_INVALID_REF, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_ADD, 'hFFFFFFFF, 0, 0, 1, 0, 0}, 1, '{sht_pkg::ST_OK, 0, 1, 1, 0}},
        '{'{sht_pkg::OP_ADD, 1, 0, 0, 1, 0, 0}, 1, '{sht_pkg::ST_OK, 1, 1, 1, 0}},
        '{'{sht_pkg::OP_ADD, 'hA5A55A5A, 0, 0, 1, 0, 0}, 0, '{sht_pkg::ST_OK, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_ADD, 'h12345678, 0, 0, 1, 0, 0}, 0, '{sht_pkg::ST_OK, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_LOOKUP, 0, 0, 1, 1, 0, 0}, 1, '{sht_pkg::ST_OK, 0, 0, 0, 'hFFFFFFFF}},
        '{'{sht_pkg::OP_LOOKUP, 0, 1, 2, 1, 0, 0}, 1, '{sht_pkg::ST_MISMATCH, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_LOOKUP, 0, 1, 1, 2, 0, 0}, 1, '{sht_pkg::ST_MISMATCH, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_REMOVE, 0, 1, 1, 1, 0, 0}, 0, '{sht_pkg::ST_OK, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_LOOKUP, 0, 1, 1, 1, 0, 0}, 1, '{sht_pkg::ST_HOLE, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_REMOVE, 0, 1, 1, 1, 0, 0}, 1, '{sht_pkg::ST_HOLE, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_REMOVE, 0, 4095, 0, 1, 0, 0}, 1, '{sht_pkg::ST_ABOVE_TOP, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_REMOVE, 0, 0, 1, 1, 1, 0}, 1, '{sht_pkg::ST_BELOW_SEG, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_POP, 0, 0, 0, 0, 4, 1}, 1, '{sht_pkg::ST_OK, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_POP, 0, 0, 0, 0, 8191, 8191}, 1,
          '{sht_pkg::ST_BAD_COOKIE, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_ADD, 'h0BADF00D, 0, 0, 1, 0, 0}, 0, '{sht_pkg::ST_OK, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_REMOVE, 0, 2, 1, 1, 0, 0}, 0, '{sht_pkg::ST_OK, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_ADD, 'h80000000, 0, 0, 1, 0, 4096}, 0, '{sht_pkg::ST_OK, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_REMOVE, 0, 3, 1, 1, 0, 0}, 0, '{sht_pkg::ST_OK, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_REMOVE, 0, 4, 1, 1, 0, 0}, 0, '{sht_pkg::ST_OK, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_REMOVE, 0, 1, 2, 2, 0, 0}, 1, '{sht_pkg::ST_MISMATCH, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_REMOVE, 0, 0, 1, 1, 0, 0}, 0, '{sht_pkg::ST_OK, 0, 0, 0, 0}},
        '{'{sht_pkg::OP_ADD, 'h7FFFFFFF, 0, 0, 1, 1, 0}, 0, '{sht_pkg::ST_OK, 0, 0, 0, 0}}
    };

    segmented_handle_table #(
        .CAPACITY    (4096),
        .SERIAL_BITS (14)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** segmented_handle_table: FAILED **");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle);
    end

    function automatic int unsigned holes_in_segment(int unsigned choles);
        return (holes_m > choles) ? holes_m - choles : 0;
    endfunction

    function automatic bit ref_matches(int unsigned idx, logic [13:0] ser, logic [1:0] kind);
        return slot_ser[idx] == ser && kind == kind_m;
    endfunction

    // Applies one request to the local table and returns the result it gives.
    function automatic t_handle_resp apply_request(t_handle_req r);
        t_handle_resp res;
        int unsigned  limit, slot, j, t, hls, idx, ctop, choles;
        bit           filled;
        res    = '{sht_pkg::ST_OK, 0, 0, 0, 0};
        idx    = 32'(r.idx);
        ctop   = 32'(r.ctop);
        choles = 32'(r.choles);
        case (r.op)
            sht_pkg::OP_ADD: begin
                limit = (max_m < CAPACITY) ? max_m : CAPACITY;
                if (r.obj == 0) begin
                    res.status = sht_pkg::ST_INVALID_REF;
                end else if (top_m >= limit) begin
                    res.status = sht_pkg::ST_OVERFLOW;
                end else begin
                    slot   = top_m;
                    filled = 1'b0;
                    if (holes_in_segment(choles) > 0) begin
                        j = top_m;
                        while (j > ctop) begin
                            j--;
                            if (!slot_live[j]) begin
                                slot   = j;
                                filled = 1'b1;
                                break;
                            end
                        end
                    end
                    slot_ser[slot]  = slot_ser[slot] + 14'd1;
                    slot_obj[slot]  = r.obj;
                    slot_live[slot] = 1'b1;
                    if (filled) holes_m--;
                    else top_m++;
                    res.index  = slot[11:0];
                    res.serial = slot_ser[slot];
                    res.kind   = kind_m;
                end
            end
            sht_pkg::OP_REMOVE: begin
                if (idx < ctop) begin
                    res.status = sht_pkg::ST_BELOW_SEG;
                end else if (idx >= top_m) begin
                    res.status = sht_pkg::ST_ABOVE_TOP;
                end else if (idx + 1 == top_m) begin
                    if (!ref_matches(idx, r.ser, r.kind)) begin
                        res.status = sht_pkg::ST_MISMATCH;
                    end else begin
                        hls = holes_in_segment(choles);
                        slot_live[idx] = 1'b0;
                        if (hls != 0) begin
                            t = top_m;
                            forever begin
                                t--;
                                if (!(t > ctop && hls != 0)) break;
                                if (slot_live[t-1]) break;
                                hls--;
                            end
                            holes_m = (hls + choles) & 13'h1FFF;
                            top_m   = t;
                        end else begin
                            top_m = idx;
                        end
                    end
                end else if (!slot_live[idx]) begin
                    res.status = sht_pkg::ST_HOLE;
                end else if (!ref_matches(idx, r.ser, r.kind)) begin
                    res.status = sht_pkg::ST_MISMATCH;
                end else begin
                    slot_live[idx] = 1'b0;
                    holes_m = (holes_m + 1) & 13'h1FFF;
                end
            end
            sht_pkg::OP_LOOKUP: begin
                if (r.kind == 0) res.status = sht_pkg::ST_INVALID_REF;
                else if (idx >= top_m) res.status = sht_pkg::ST_ABOVE_TOP;
                else if (!slot_live[idx]) res.status = sht_pkg::ST_HOLE;
                else if (!ref_matches(idx, r.ser, r.kind)) res.status = sht_pkg::ST_MISMATCH;
                else res.object = slot_obj[idx];
            end
            default: begin
                if (ctop > top_m || choles >= ctop) res.status = sht_pkg::ST_BAD_COOKIE;
            end
        endcase
        return res;
    endfunction

    // Mostly live references and cookies that fit the table, the rest raw noise.
    function automatic t_handle_req pick_request();
        t_handle_req r;
        int unsigned roll, pick;
        bit          tidy;
        roll     = $urandom_range(99);
        tidy     = ($urandom_range(99) < 75);
        r.obj    = $urandom;
        r.idx    = 12'($urandom);
        r.ser    = 14'($urandom);
        r.kind   = 2'($urandom);
        r.ctop   = 13'($urandom);
        r.choles = 13'($urandom);
        if ($urandom_range(19) == 0) r.obj = '0;
        if (tidy) begin
            r.ctop   = ($urandom_range(2) == 0) ? 13'($urandom_range(top_m)) : 13'd0;
            r.choles = ($urandom_range(2) == 0) ? 13'($urandom_range(holes_m)) : 13'd0;
            if (top_m > 0) begin
                pick   = ($urandom_range(2) == 0) ? top_m - 1 : $urandom_range(top_m - 1);
                r.idx  = 12'(pick);
                r.ser  = slot_ser[pick];
                r.kind = kind_m;
            end
        end
        if (roll < 40 && top_m < TOP_CAP) r.op = sht_pkg::OP_ADD;
        else if (roll < 68) r.op = sht_pkg::OP_REMOVE;
        else if (roll < 92) r.op = sht_pkg::OP_LOOKUP;
        else r.op = sht_pkg::OP_POP;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("result %0d: %s is 0x%0h, expected 0x%0h", checked, field, got, want);
    endtask

    task automatic send_request(t_handle_req r, bit typed, t_handle_resp want);
        t_handle_resp due;
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, r.choles, r.ctop, r.kind, r.ser, r.idx, r.obj};
        s_axis_tuser  <= r.op;
        do @(posedge i_clk); while (!s_axis_tready);
        due = apply_request(r);
        if (typed) due = want;
        results_due.push_back(due);
        op_count[r.op]++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [sht_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value[12:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == sht_pkg::CFG_MAX_ENTRIES) max_m = value & 13'h1FFF;
        else kind_m = value[1:0];
    endtask

    always @(posedge i_clk) begin : result_check
        t_handle_resp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                report_mismatch("result with nothing due", m_axis_tdata[31:0], 32'd0);
            end else begin
                want = results_due.pop_front();
                if (m_axis_tdata[2:0] != want.status)
                    report_mismatch("status", 32'(m_axis_tdata[2:0]), 32'(want.status));
                if (m_axis_tdata[14:3] != want.index)
                    report_mismatch("index", 32'(m_axis_tdata[14:3]), 32'(want.index));
                if (m_axis_tdata[28:15] != want.serial)
                    report_mismatch("serial", 32'(m_axis_tdata[28:15]), 32'(want.serial));
                if (m_axis_tdata[30:29] != want.kind)
                    report_mismatch("kind", 32'(m_axis_tdata[30:29]), 32'(want.kind));
                if (m_axis_tdata[62:31] != want.object)
                    report_mismatch("object", m_axis_tdata[62:31], want.object);
                checked++;
            end
        end
    end

    initial begin
        t_handle_resp none;
        none = '{sht_pkg::ST_OK, 0, 0, 0, 0};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) send_request(plan[k].req, plan[k].typed, plan[k].want);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            snd_idle = phase_snd[p];
            rcv_idle = phase_rcv[p];
            write_reg(sht_pkg::CFG_MAX_ENTRIES, phase_max[p]);
            write_reg(sht_pkg::CFG_TABLE_KIND, phase_kind[p]);
            for (int n = 0; n < phase_items[p]; n++) begin
                if (n == phase_items[p] / 2) drain();
                send_request(pick_request(), 1'b0, none);
            end
            drain();
        end
        repeat (40) @(posedge i_clk);

        if (results_due.size() != 0)
            report_mismatch("results never delivered", results_due.size(), 32'd0);
        $display("Covered %0d requests: %0d add, %0d remove, %0d lookup, %0d pop check.",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("Compared %0d results over %0d register settings and three stall patterns.",
                 checked, PHASES + 1);
        if (errors == 0) begin
            $display("** segmented_handle_table: PASSED **");
        end else begin
            $display("** segmented_handle_table: FAILED **");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/sht_pkg.sv
hdl/sht_slot_mem.sv
hdl/sht_ctrl.sv
hdl/segmented_handle_table.sv
tb/tb.sv
